// ===== hdl/bsvm_pkg.sv =====
package bsvm_pkg;

   localparam int STACK_DEPTH_DEF = 1024;
   localparam int ADDR_W          = 17;
   localparam int LANES           = 8;
   localparam int KIND_W          = 4;
   localparam int REQ_TDATA_W     = 104;
   localparam int RSP_TDATA_W     = 88;

   typedef enum logic [3:0] {
      K_NOOP       = 4'd0,
      K_JUMP       = 4'd1,
      K_POP        = 4'd2,
      K_PUSH_LIT   = 4'd3,
      K_PUSH_LOCAL = 4'd4,
      K_COPY       = 4'd5,
      K_STORE      = 4'd6,
      K_ADD        = 4'd7,
      K_JGE32      = 4'd8,
      K_OUT        = 4'd9,
      K_EXIT       = 4'd10,
      K_UNKNOWN    = 4'd11
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_UNKNOWN   = 2'd1,
      ERR_OVERFLOW  = 2'd2,
      ERR_UNDERFLOW = 2'd3
   } err_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_READ,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [15:0] pc;
      kind_type    kind;
      logic [1:0]  size_code;
      logic [3:0]  nbytes;
      logic [4:0]  pop_bytes;
      logic        grow;
      logic [15:0] offset;
      logic [63:0] literal;
   } item_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } q_ctl_type;

   function automatic logic [63:0] sext(input logic [63:0] v, input logic [1:0] sc);
      logic [63:0] r;
      unique case (sc)
         2'd0:    r = {{56{v[7]}}, v[7:0]};
         2'd1:    r = {{48{v[15]}}, v[15:0]};
         2'd2:    r = {{32{v[31]}}, v[31:0]};
         default: r = v;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/bsvm_ram.sv =====
module bsvm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hdl/bsvm_front.sv =====
module bsvm_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bsvm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic [bsvm_pkg::KIND_W-1:0]       req_tuser,
   input  bsvm_pkg::q_ctl_type               ctl,
   output logic                              head_valid,
   output bsvm_pkg::item_type                head
);

   bsvm_pkg::item_type dec;
   bsvm_pkg::item_type q_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push;

   always_comb begin
      dec.pc        = req_tdata[15:0];
      dec.size_code = req_tdata[17:16];
      dec.offset    = req_tdata[33:18];
      dec.literal   = req_tdata[97:34];
      dec.nbytes    = 4'd1 << dec.size_code;
      unique case (req_tuser)
         4'd0:    dec.kind = bsvm_pkg::K_NOOP;
         4'd1:    dec.kind = bsvm_pkg::K_JUMP;
         4'd2:    dec.kind = bsvm_pkg::K_POP;
         4'd3:    dec.kind = bsvm_pkg::K_PUSH_LIT;
         4'd4:    dec.kind = bsvm_pkg::K_PUSH_LOCAL;
         4'd5:    dec.kind = bsvm_pkg::K_COPY;
         4'd6:    dec.kind = bsvm_pkg::K_STORE;
         4'd7:    dec.kind = bsvm_pkg::K_ADD;
         4'd8:    dec.kind = bsvm_pkg::K_JGE32;
         4'd9:    dec.kind = bsvm_pkg::K_OUT;
         4'd10:   dec.kind = bsvm_pkg::K_EXIT;
         default: dec.kind = bsvm_pkg::K_UNKNOWN;
      endcase
      // bytes the instruction must find on the stack
      unique case (dec.kind)
         bsvm_pkg::K_POP, bsvm_pkg::K_COPY, bsvm_pkg::K_STORE, bsvm_pkg::K_OUT:
            dec.pop_bytes = {1'b0, dec.nbytes};
         bsvm_pkg::K_ADD:   dec.pop_bytes = {dec.nbytes, 1'b0};
         bsvm_pkg::K_JGE32: dec.pop_bytes = 5'd8;
         default:           dec.pop_bytes = 5'd0;
      endcase
      dec.grow = (dec.kind == bsvm_pkg::K_PUSH_LIT) || (dec.kind == bsvm_pkg::K_PUSH_LOCAL) ||
                 (dec.kind == bsvm_pkg::K_COPY);
   end

   assign req_tready = (count_ff != 2'd2) && !ctl.clearing;
   assign push       = req_tvalid && req_tready;
   assign head_valid = (count_ff != 2'd0);
   assign head       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = ctl.pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, ctl.pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

// ===== hdl/bsvm_back.sv =====
module bsvm_back #(
   parameter int STACK_DEPTH_BYTES = bsvm_pkg::STACK_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  bsvm_pkg::item_type                head,
   output bsvm_pkg::q_ctl_type               ctl,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bsvm_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int LANES = bsvm_pkg::LANES;
   localparam int AW    = bsvm_pkg::ADDR_W;
   localparam int ROWS  = (STACK_DEPTH_BYTES + LANES - 1) / LANES;
   localparam int RAW   = $clog2(ROWS);
   localparam int TW    = $clog2(STACK_DEPTH_BYTES + 1);
   localparam logic [AW:0] DEPTH_X = (AW+1)'(STACK_DEPTH_BYTES);

   bsvm_pkg::state_type state_ff, state_in;
   logic [TW-1:0]       top_ff, top_in;
   logic [RAW-1:0]      clr_row_ff, clr_row_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [bsvm_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [AW-1:0] top_x, n_x, addr_a, addr_b, addr_w;
   logic [3:0]    rd_n;
   logic [RAW-1:0] ra_a [LANES];
   logic [RAW-1:0] ra_b [LANES];
   logic [RAW-1:0] wa   [LANES];
   logic [7:0]     rd_a [LANES];
   logic [7:0]     rd_b [LANES];
   logic [7:0]     wd   [LANES];
   logic           we   [LANES];

   logic [63:0] word_a, word_b, wdata;
   logic        complete, clearing, under, over, wr_any;
   bsvm_pkg::err_type err;
   logic [15:0] next_pc;
   logic        halt, out_valid;
   logic [63:0] out_value;

   assign top_x = AW'(top_ff);
   assign n_x   = AW'(head.nbytes);

   // read windows come straight from the queue head, stable while it waits
   always_comb begin
      priority case (head.kind)
         bsvm_pkg::K_PUSH_LOCAL: addr_a = {1'b0, head.offset};
         bsvm_pkg::K_JGE32:      addr_a = top_x - AW'(8);
         default:                addr_a = top_x - n_x;
      endcase
      addr_b = top_x - (n_x << 1);
      priority case (head.kind)
         bsvm_pkg::K_ADD:   addr_w = addr_b;
         bsvm_pkg::K_STORE: addr_w = {1'b0, head.offset};
         default:           addr_w = top_x;
      endcase
      rd_n = (head.kind == bsvm_pkg::K_JGE32) ? 4'd8 : head.nbytes;
   end

   for (genvar k = 0; k < LANES; k++) begin : g_bank
      assign ra_a[k] = RAW'((addr_a >> 3) + AW'(3'(k) < addr_a[2:0]));
      assign ra_b[k] = RAW'((addr_b >> 3) + AW'(3'(k) < addr_b[2:0]));

      bsvm_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
         .clock     (clock),
         .wr_en     (we[k]),
         .wr_addr   (wa[k]),
         .wr_data   (wd[k]),
         .rd_addr_a (ra_a[k]),
         .rd_addr_b (ra_b[k]),
         .rd_data_a (rd_a[k]),
         .rd_data_b (rd_b[k])
      );
   end

   // gather bytes; drop those past the width or beyond the stack
   always_comb begin
      logic [2:0] la, lb;
      for (int i = 0; i < LANES; i++) begin
         la = addr_a[2:0] + 3'(i);
         lb = addr_b[2:0] + 3'(i);
         word_a[8*i +: 8] = ((4'(i) < rd_n) && (({1'b0, addr_a} + (AW+1)'(i)) < DEPTH_X)) ?
                            rd_a[la] : 8'h00;
         word_b[8*i +: 8] = ((4'(i) < head.nbytes) &&
                            (({1'b0, addr_b} + (AW+1)'(i)) < DEPTH_X)) ? rd_b[lb] : 8'h00;
      end
   end

   always_comb begin
      under = top_x < AW'(head.pop_bytes);
      over  = head.grow && (({1'b0, top_x} + {1'b0, n_x}) > DEPTH_X);
      priority if (head.kind == bsvm_pkg::K_UNKNOWN) err = bsvm_pkg::ERR_UNKNOWN;
      else if (under)                               err = bsvm_pkg::ERR_UNDERFLOW;
      else if (over)                                err = bsvm_pkg::ERR_OVERFLOW;
      else                                          err = bsvm_pkg::ERR_NONE;

      next_pc = head.pc + 16'd1;
      unique case (head.kind)
         bsvm_pkg::K_JUMP:       next_pc = head.offset;
         bsvm_pkg::K_PUSH_LIT:   next_pc = head.pc + 16'd1 + {12'd0, head.nbytes};
         bsvm_pkg::K_PUSH_LOCAL,
         bsvm_pkg::K_STORE:      next_pc = head.pc + 16'd3;
         bsvm_pkg::K_JGE32:      next_pc = (word_a[31:0] >= word_a[63:32]) ? head.offset :
                                           head.pc + 16'd3;
         bsvm_pkg::K_EXIT:       next_pc = head.pc;
         default:                next_pc = head.pc + 16'd1;
      endcase
      halt = (head.kind == bsvm_pkg::K_EXIT);
      if (err != bsvm_pkg::ERR_NONE) begin
         next_pc = head.pc;
         halt    = 1'b1;
      end
      out_valid = (head.kind == bsvm_pkg::K_OUT) && (err == bsvm_pkg::ERR_NONE);
      out_value = out_valid ? bsvm_pkg::sext(word_a, head.size_code) : 64'd0;

      unique case (head.kind)
         bsvm_pkg::K_PUSH_LIT: wdata = head.literal;
         bsvm_pkg::K_ADD:      wdata = word_a + word_b;
         default:              wdata = word_a;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         bsvm_pkg::ST_CLEAR: state_in = (clr_row_ff == RAW'(ROWS - 1)) ? bsvm_pkg::ST_READ :
                                        bsvm_pkg::ST_CLEAR;
         bsvm_pkg::ST_READ:  state_in = head_valid ? bsvm_pkg::ST_EXEC : bsvm_pkg::ST_READ;
         bsvm_pkg::ST_EXEC:  state_in = complete ? bsvm_pkg::ST_READ : bsvm_pkg::ST_EXEC;
         default:            state_in = bsvm_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      clearing = (state_ff == bsvm_pkg::ST_CLEAR);
      complete = (state_ff == bsvm_pkg::ST_EXEC) && (!rsp_valid_ff || rsp_tready);
      wr_any   = complete && (err == bsvm_pkg::ERR_NONE) &&
                 (head.grow || (head.kind == bsvm_pkg::K_STORE) ||
                  (head.kind == bsvm_pkg::K_ADD));
      ctl.pop      = complete;
      ctl.clearing = clearing;
      clr_row_in   = clearing ? clr_row_ff + RAW'(1) : clr_row_ff;

      top_in = top_ff;
      if (complete && (err == bsvm_pkg::ERR_NONE)) begin
         // copy only reads the top bytes it needs, so it grows without popping
         top_in = TW'(top_x + ((head.grow || (head.kind == bsvm_pkg::K_ADD)) ? n_x : AW'(0))
                  - ((head.kind == bsvm_pkg::K_COPY) ? AW'(0) : AW'(head.pop_bytes)));
      end

      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (complete) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'd0, err, halt, out_value, out_valid, next_pc};
      end
   end

   always_comb begin
      logic [2:0] li;
      for (int k = 0; k < LANES; k++) begin
         li = 3'(k) - addr_w[2:0];
         if (clearing) begin
            we[k] = 1'b1;
            wa[k] = clr_row_ff;
            wd[k] = 8'h00;
         end else begin
            we[k] = wr_any && ({1'b0, li} < head.nbytes) &&
                    (({1'b0, addr_w} + (AW+1)'(li)) < DEPTH_X);
            wa[k] = RAW'((addr_w >> 3) + AW'(3'(k) < addr_w[2:0]));
            wd[k] = 8'(wdata >> {li, 3'b000});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsvm_pkg::ST_CLEAR;
         top_ff       <= '0;
         clr_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         clr_row_ff   <= clr_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hdl/byte_stack_vm_execute_unit.sv =====
// An accepted word passes the front queue, a read on the eight byte-lane stack banks, then
// an execute step that writes back and registers the result; execute holds while a result
// word is stalled, and the front queue can take the next word meanwhile.
// Reset: synchronous, active high; the stack is zeroed by a pass over its STACK_DEPTH_BYTES/8
// rows (128 by default) during which req_tready stays low.
module byte_stack_vm_execute_unit #(
   parameter int STACK_DEPTH_BYTES = bsvm_pkg::STACK_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pc[15:0], size_code[17:16], offset[33:18], literal[97:34], zero fill
   input  logic [bsvm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // kind[3:0]
   input  logic [bsvm_pkg::KIND_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // next_pc[15:0], out_valid[16], out_value[80:17], halt[81], error_code[83:82], zero fill
   output logic [bsvm_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   bsvm_pkg::q_ctl_type ctl;
   bsvm_pkg::item_type  head;
   logic                head_valid;

   bsvm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .ctl        (ctl),
      .head_valid (head_valid),
      .head       (head)
   );

   bsvm_back #(.STACK_DEPTH_BYTES(STACK_DEPTH_BYTES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .ctl        (ctl),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== hdl/bsvm_checker.sv =====
module bsvm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [bsvm_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   // no words in flight after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid && !req_tready)
      else $error("unit not idle after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   a_err_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[83:82] != 2'd0) |-> rsp_tdata[81] && !rsp_tdata[16])
      else $error("error without halt");

   a_out_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[16] |-> (rsp_tdata[80:17] == 64'd0))
      else $error("output value without out_valid");

   a_out_no_halt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[16] |-> !rsp_tdata[81])
      else $error("output with halt");

endmodule

bind byte_stack_vm_execute_unit bsvm_checker u_bsvm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
